// File: design/tau_pkg.sv
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// tau_pkg
// Shared constants and types for the triangle altitude unit.
// -----------------------------------------------------------------------------
package tau_pkg;

   localparam int COORD_WIDTH_DEF         = 16;
   localparam int EXTRA_FRACTION_BITS_DEF = 8;
   localparam int ALT_WIDTH               = 25;

   // control that travels with each item through the root lanes
   typedef struct packed {
      logic valid;
      logic zero;   // side length is zero: altitude forced to 0
      logic tag;    // side flag carried alongside (degenerate)
   } tau_ctl_type;

   function automatic int max_int(input int a, input int b);
      return (a > b) ? a : b;
   endfunction

endpackage

// File: design/tau_front.sv
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// tau_front
// Five-stage front end: edge vectors, products, doubled area and squared
// side lengths, then the squared scaled area in two partial-product stages.
// -----------------------------------------------------------------------------
module tau_front #(
   parameter int COORD_WIDTH         = tau_pkg::COORD_WIDTH_DEF,
   parameter int EXTRA_FRACTION_BITS = tau_pkg::EXTRA_FRACTION_BITS_DEF
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   in_valid,
   input  logic signed [COORD_WIDTH-1:0]          ax,
   input  logic signed [COORD_WIDTH-1:0]          ay,
   input  logic signed [COORD_WIDTH-1:0]          bx,
   input  logic signed [COORD_WIDTH-1:0]          by_coord,
   input  logic signed [COORD_WIDTH-1:0]          cx,
   input  logic signed [COORD_WIDTH-1:0]          cy,
   output logic                                   out_valid,
   output logic [2*(2*COORD_WIDTH+3)+2*EXTRA_FRACTION_BITS-1:0] k2,
   output logic [2*COORD_WIDTH+2:0]               sab,
   output logic [2*COORD_WIDTH+2:0]               sbc,
   output logic [2*COORD_WIDTH+2:0]               sac,
   output logic                                   degen
);

   localparam int MW  = COORD_WIDTH + 1;       // magnitude width
   localparam int PW  = 2 * MW;                // product width
   localparam int SW  = PW + 1;                // sum / cross width
   localparam int H   = (SW + 1) / 2;          // half of cross for squaring
   localparam int C2W = 2 * SW;
   localparam int RW  = C2W + 2 * EXTRA_FRACTION_BITS;

   function automatic logic [MW-1:0] mag_of(input logic [MW-1:0] d);
      return d[MW-1] ? MW'(-d) : d;
   endfunction

   // stage 1: differences
   logic [MW-1:0] d_ubx, d_uby, d_ucx, d_ucy, d_vbx, d_vby;
   logic [MW-1:0] m_ubx_ff, m_uby_ff, m_ucx_ff, m_ucy_ff, m_vbx_ff, m_vby_ff;
   logic          n1_ff, n2_ff, v1_ff;

   assign d_ubx = {bx[COORD_WIDTH-1], bx} - {ax[COORD_WIDTH-1], ax};
   assign d_uby = {by_coord[COORD_WIDTH-1], by_coord} - {ay[COORD_WIDTH-1], ay};
   assign d_ucx = {cx[COORD_WIDTH-1], cx} - {ax[COORD_WIDTH-1], ax};
   assign d_ucy = {cy[COORD_WIDTH-1], cy} - {ay[COORD_WIDTH-1], ay};
   assign d_vbx = {cx[COORD_WIDTH-1], cx} - {bx[COORD_WIDTH-1], bx};
   assign d_vby = {cy[COORD_WIDTH-1], cy} - {by_coord[COORD_WIDTH-1], by_coord};

   always_ff @(posedge clock) begin
      m_ubx_ff <= mag_of(d_ubx);
      m_uby_ff <= mag_of(d_uby);
      m_ucx_ff <= mag_of(d_ucx);
      m_ucy_ff <= mag_of(d_ucy);
      m_vbx_ff <= mag_of(d_vbx);
      m_vby_ff <= mag_of(d_vby);
      n1_ff    <= d_ubx[MW-1] ^ d_ucy[MW-1];
      n2_ff    <= d_uby[MW-1] ^ d_ucx[MW-1];
   end

   // stage 2: products
   logic [PW-1:0] p1_ff, p2_ff, q_ubx_ff, q_uby_ff, q_ucx_ff, q_ucy_ff, q_vbx_ff, q_vby_ff;
   logic          n1b_ff, n2b_ff, v2_ff;

   always_ff @(posedge clock) begin
      p1_ff    <= PW'(m_ubx_ff) * PW'(m_ucy_ff);
      p2_ff    <= PW'(m_uby_ff) * PW'(m_ucx_ff);
      q_ubx_ff <= PW'(m_ubx_ff) * PW'(m_ubx_ff);
      q_uby_ff <= PW'(m_uby_ff) * PW'(m_uby_ff);
      q_ucx_ff <= PW'(m_ucx_ff) * PW'(m_ucx_ff);
      q_ucy_ff <= PW'(m_ucy_ff) * PW'(m_ucy_ff);
      q_vbx_ff <= PW'(m_vbx_ff) * PW'(m_vbx_ff);
      q_vby_ff <= PW'(m_vby_ff) * PW'(m_vby_ff);
      n1b_ff   <= n1_ff;
      n2b_ff   <= n2_ff;
   end

   // stage 3: doubled area and squared lengths
   logic [SW-1:0] cross_in, cross_ff, sab3_ff, sbc3_ff, sac3_ff;
   logic          dg3_ff, v3_ff;

   always_comb begin
      if (n1b_ff == n2b_ff) begin
         cross_in = (p1_ff >= p2_ff) ? SW'(p1_ff - p2_ff) : SW'(p2_ff - p1_ff);
      end else begin
         cross_in = SW'(p1_ff) + SW'(p2_ff);
      end
   end

   always_ff @(posedge clock) begin
      cross_ff <= cross_in;
      sab3_ff  <= SW'(q_ubx_ff) + SW'(q_uby_ff);
      sbc3_ff  <= SW'(q_vbx_ff) + SW'(q_vby_ff);
      sac3_ff  <= SW'(q_ucx_ff) + SW'(q_ucy_ff);
      dg3_ff   <= ((q_ubx_ff | q_uby_ff) == '0) || ((q_vbx_ff | q_vby_ff) == '0)
                  || ((q_ucx_ff | q_ucy_ff) == '0);
   end

   // stage 4: partial products of cross squared
   logic [2*H-1:0] cext;
   logic [H-1:0]   c_hi, c_lo;
   logic [2*H-1:0] hh_ff, hl_ff, ll_ff;
   logic [SW-1:0]  sab4_ff, sbc4_ff, sac4_ff;
   logic           dg4_ff, v4_ff;

   assign cext = (2*H)'(cross_ff);
   assign c_hi = cext[2*H-1:H];
   assign c_lo = cext[H-1:0];

   always_ff @(posedge clock) begin
      hh_ff   <= (2*H)'(c_hi) * (2*H)'(c_hi);
      hl_ff   <= (2*H)'(c_hi) * (2*H)'(c_lo);
      ll_ff   <= (2*H)'(c_lo) * (2*H)'(c_lo);
      sab4_ff <= sab3_ff;
      sbc4_ff <= sbc3_ff;
      sac4_ff <= sac3_ff;
      dg4_ff  <= dg3_ff;
   end

   // stage 5: sum partials, scale by the extra fraction bits
   logic [4*H-1:0] c2_sum;
   logic [RW-1:0]  k2_ff;
   logic [SW-1:0]  sab5_ff, sbc5_ff, sac5_ff;
   logic           dg5_ff, v5_ff;

   assign c2_sum = ((4*H)'(hh_ff) << (2*H)) + ((4*H)'(hl_ff) << (H+1)) + (4*H)'(ll_ff);

   always_ff @(posedge clock) begin
      k2_ff   <= RW'(C2W'(c2_sum)) << (2*EXTRA_FRACTION_BITS);
      sab5_ff <= sab4_ff;
      sbc5_ff <= sbc4_ff;
      sac5_ff <= sac4_ff;
      dg5_ff  <= dg4_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
      end else begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
         v5_ff <= v4_ff;
      end
   end

   assign out_valid = v5_ff;
   assign k2        = k2_ff;
   assign sab       = sab5_ff;
   assign sbc       = sbc5_ff;
   assign sac       = sac5_ff;
   assign degen     = dg5_ff;

endmodule

// File: design/tau_root_stage.sv
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// tau_root_stage
// One bit of the altitude search: keeps R = K^2 - q^2*S and P = q*S and tries
// setting bit BIT of q with one wide add and compare.
// -----------------------------------------------------------------------------
module tau_root_stage #(
   parameter int SW  = 35,
   parameter int LW  = 90,
   parameter int BIT = 0
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  tau_pkg::tau_ctl_type                   ctl_i,
   input  logic [LW-1:0]                          r_i,
   input  logic [tau_pkg::ALT_WIDTH+SW-1:0]       p_i,
   input  logic [SW-1:0]                          s_i,
   input  logic [tau_pkg::ALT_WIDTH-1:0]          q_i,
   output tau_pkg::tau_ctl_type                   ctl_o,
   output logic [LW-1:0]                          r_o,
   output logic [tau_pkg::ALT_WIDTH+SW-1:0]       p_o,
   output logic [SW-1:0]                          s_o,
   output logic [tau_pkg::ALT_WIDTH-1:0]          q_o
);

   localparam int AW = tau_pkg::ALT_WIDTH;
   localparam int PW = AW + SW;

   logic [LW-1:0] d;
   logic          take;
   logic [LW-1:0] r_ff;
   logic [PW-1:0] p_ff;
   logic [SW-1:0] s_ff;
   logic [AW-1:0] q_ff;
   tau_pkg::tau_ctl_type ctl_ff;

   // increase of q^2*S when bit BIT is set: 2^(BIT+1)*P + 2^(2*BIT)*S
   assign d    = (LW'(p_i) << (BIT + 1)) + (LW'(s_i) << (2 * BIT));
   assign take = (d <= r_i);

   always_ff @(posedge clock) begin
      r_ff <= take ? (r_i - d) : r_i;
      p_ff <= take ? (p_i + (PW'(s_i) << BIT)) : p_i;
      q_ff <= take ? (q_i | (AW'(1) << BIT)) : q_i;
      s_ff <= s_i;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff <= '0;
      end else begin
         ctl_ff <= ctl_i;
      end
   end

   assign ctl_o = ctl_ff;
   assign r_o   = r_ff;
   assign p_o   = p_ff;
   assign s_o   = s_ff;
   assign q_o   = q_ff;

endmodule

// File: design/tau_alt_lane.sv
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// tau_alt_lane
// One altitude: a chain of ALT_WIDTH search stages, most significant bit first,
// with a zero-length side forcing the result to 0.
// -----------------------------------------------------------------------------
module tau_alt_lane #(
   parameter int SW = 35,
   parameter int RW = 86
) (
   input  logic                            clock,
   input  logic                            reset,
   input  tau_pkg::tau_ctl_type            ctl_i,
   input  logic [RW-1:0]                   k2_i,
   input  logic [SW-1:0]                   s_i,
   output tau_pkg::tau_ctl_type            ctl_o,
   output logic [tau_pkg::ALT_WIDTH-1:0]   alt_o
);

   localparam int AW = tau_pkg::ALT_WIDTH;
   localparam int LW = tau_pkg::max_int(RW, 2 * AW + SW + 1);
   localparam int PW = AW + SW;

   tau_pkg::tau_ctl_type ctl_w [AW+1];
   logic [LW-1:0] r_w [AW+1];
   logic [PW-1:0] p_w [AW+1];
   logic [SW-1:0] s_w [AW+1];
   logic [AW-1:0] q_w [AW+1];

   assign ctl_w[0] = ctl_i;
   assign r_w[0]   = LW'(k2_i);
   assign p_w[0]   = '0;
   assign s_w[0]   = s_i;
   assign q_w[0]   = '0;

   for (genvar i = 0; i < AW; i++) begin : g_stage
      tau_root_stage #(
         .SW  (SW),
         .LW  (LW),
         .BIT (AW - 1 - i)
      ) u_stage (
         .clock (clock),
         .reset (reset),
         .ctl_i (ctl_w[i]),
         .r_i   (r_w[i]),
         .p_i   (p_w[i]),
         .s_i   (s_w[i]),
         .q_i   (q_w[i]),
         .ctl_o (ctl_w[i+1]),
         .r_o   (r_w[i+1]),
         .p_o   (p_w[i+1]),
         .s_o   (s_w[i+1]),
         .q_o   (q_w[i+1])
      );
   end

   assign ctl_o = ctl_w[AW];
   assign alt_o = ctl_w[AW].zero ? '0 : q_w[AW];

endmodule

// File: design/triangle_altitudes_unit.sv
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// triangle_altitudes_unit
// Altitudes of a triangle onto its three sides from signed vertex coordinates.
// -----------------------------------------------------------------------------
// Fully pipelined: one triangle is taken every cycle (busy stays low) and its
// result shows on rsp_valid once the start transfer has passed through the five front
// stages (edges, products, area and lengths, squared area in two steps), one
// stage per result bit in each of three parallel altitude lanes (25), and the
// output register. The receiver cannot stall, so results must be taken in the
// cycle they appear. Altitudes are truncated, saturate at 2^25-1, and a side of
// zero length raises degenerate and reads as 0.
// -----------------------------------------------------------------------------
module triangle_altitudes_unit #(
   parameter int COORD_WIDTH         = tau_pkg::COORD_WIDTH_DEF,
   parameter int EXTRA_FRACTION_BITS = tau_pkg::EXTRA_FRACTION_BITS_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   output logic                                 busy,
   input  logic signed [COORD_WIDTH-1:0]        req_ax,
   input  logic signed [COORD_WIDTH-1:0]        req_ay,
   input  logic signed [COORD_WIDTH-1:0]        req_bx,
   input  logic signed [COORD_WIDTH-1:0]        req_by_coord,
   input  logic signed [COORD_WIDTH-1:0]        req_cx,
   input  logic signed [COORD_WIDTH-1:0]        req_cy,
   output logic                                 rsp_valid,
   output logic [tau_pkg::ALT_WIDTH-1:0]        rsp_alt_ab,
   output logic [tau_pkg::ALT_WIDTH-1:0]        rsp_alt_bc,
   output logic [tau_pkg::ALT_WIDTH-1:0]        rsp_alt_ac,
   output logic                                 rsp_degenerate
);

   localparam int AW = tau_pkg::ALT_WIDTH;
   localparam int SW = 2 * (COORD_WIDTH + 1) + 1;
   localparam int RW = 2 * SW + 2 * EXTRA_FRACTION_BITS;

   logic          f_valid;
   logic [RW-1:0] f_k2;
   logic [SW-1:0] f_sab, f_sbc, f_sac;
   logic          f_degen;

   tau_pkg::tau_ctl_type ctl_ab, ctl_bc, ctl_ac;
   tau_pkg::tau_ctl_type out_ab;
   logic [AW-1:0] alt_ab, alt_bc, alt_ac;

   logic          rsp_valid_ff;
   logic [AW-1:0] alt_ab_ff, alt_bc_ff, alt_ac_ff;
   logic          degen_ff;

   assign busy = 1'b0;

   tau_front #(
      .COORD_WIDTH         (COORD_WIDTH),
      .EXTRA_FRACTION_BITS (EXTRA_FRACTION_BITS)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (start),
      .ax        (req_ax),
      .ay        (req_ay),
      .bx        (req_bx),
      .by_coord  (req_by_coord),
      .cx        (req_cx),
      .cy        (req_cy),
      .out_valid (f_valid),
      .k2        (f_k2),
      .sab       (f_sab),
      .sbc       (f_sbc),
      .sac       (f_sac),
      .degen     (f_degen)
   );

   // the AB lane carries the degenerate flag and the valid for the result
   assign ctl_ab = '{valid: f_valid, zero: (f_sab == '0), tag: f_degen};
   assign ctl_bc = '{valid: f_valid, zero: (f_sbc == '0), tag: 1'b0};
   assign ctl_ac = '{valid: f_valid, zero: (f_sac == '0), tag: 1'b0};

   tau_alt_lane #(.SW(SW), .RW(RW)) u_lane_ab (
      .clock (clock), .reset (reset), .ctl_i (ctl_ab), .k2_i (f_k2), .s_i (f_sab),
      .ctl_o (out_ab), .alt_o (alt_ab)
   );

   tau_alt_lane #(.SW(SW), .RW(RW)) u_lane_bc (
      .clock (clock), .reset (reset), .ctl_i (ctl_bc), .k2_i (f_k2), .s_i (f_sbc),
      .ctl_o (), .alt_o (alt_bc)
   );

   tau_alt_lane #(.SW(SW), .RW(RW)) u_lane_ac (
      .clock (clock), .reset (reset), .ctl_i (ctl_ac), .k2_i (f_k2), .s_i (f_sac),
      .ctl_o (), .alt_o (alt_ac)
   );

   always_ff @(posedge clock) begin
      alt_ab_ff <= alt_ab;
      alt_bc_ff <= alt_bc;
      alt_ac_ff <= alt_ac;
      degen_ff  <= out_ab.tag;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= out_ab.valid;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_alt_ab     = alt_ab_ff;
   assign rsp_alt_bc     = alt_bc_ff;
   assign rsp_alt_ac     = alt_ac_ff;
   assign rsp_degenerate = degen_ff;

endmodule
